### rtl/lci_pkg.sv
// ----------------------------------------------------------------------------
// Line/circle intersection package
// Configuration register map and the register bundle shared by the top
// level and the front end.
// ----------------------------------------------------------------------------
package lci_pkg;

	// configuration bus
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int REG_SEL_BIT = 2;

	// depth of the queue between front and back end
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	typedef enum logic {
		REG_MIN_DIRECTION_NORM = 1'b0,
		REG_TANGENT_TOLERANCE  = 1'b1
	} lci_reg_t;

	// configuration register bundle
	typedef struct packed {
		logic [CFG_DATA_W-1:0] min_direction_norm;
		logic [CFG_DATA_W-1:0] tangent_tolerance;
	} lci_cfg_t;

endpackage

### rtl/lci_fifo.sv
// ----------------------------------------------------------------------------
// Line/circle intersection queue
// Small flop-based FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lci_fifo import lci_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full      = (cnt_q == (PW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

### rtl/lci_front.sv
// ----------------------------------------------------------------------------
// Line/circle intersection front end
// Accepts rays, forms the quadratic coefficients and the discriminant,
// and classifies each ray as no hit, tangent or two-root.
// ----------------------------------------------------------------------------
module lci_front import lci_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lci_cfg_t          cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [((7*COORD_WIDTH-1)+7)/8*8-1:0] s_tdata,
	output logic              q_push,
	output logic [12*COORD_WIDTH+7:0] q_data,
	input  logic              q_full
);

	localparam int CW   = COORD_WIDTH;
	localparam int LW   = CW + 1;
	localparam int AW   = 2 * CW;
	localparam int BW   = 2 * CW + 2;
	localparam int BM   = BW - 1;
	localparam int CWD  = 2 * CW + 3;
	localparam int CM   = CWD - 1;
	localparam int PRW  = 4 * CW + 2;
	localparam int DW   = 4 * CW + 4;
	localparam int CMPW = (AW > CFG_DATA_W) ? AW : CFG_DATA_W;

	logic fen;

	logic signed [CW-1:0] in_sx, in_sy, in_du, in_dv, in_cx, in_cy;
	logic [CW-2:0]        in_r;

	// stage 1: ray relative to center
	logic                 vld_s1;
	logic signed [CW-1:0] sx_s1, sy_s1, du_s1, dv_s1;
	logic signed [LW-1:0] lx_s1, ly_s1;
	logic [CW-2:0]        r_s1;
	// stage 2: products
	logic                 vld_s2;
	logic signed [CW-1:0] sx_s2, sy_s2, du_s2, dv_s2;
	logic signed [AW-1:0] uu_s2, vv_s2;
	logic signed [CW+LW-1:0] ulx_s2, vly_s2;
	logic signed [2*LW-1:0]  lxx_s2, lyy_s2;
	logic [2*CW-3:0]      rr_s2;
	// stage 3: coefficients
	logic                 vld_s3;
	logic signed [CW-1:0] sx_s3, sy_s3, du_s3, dv_s3;
	logic [AW-1:0]        a_s3;
	logic signed [BW-1:0] bh_s3;
	logic signed [CWD-1:0] c_s3;
	// stage 4: magnitudes and threshold check
	logic                 vld_s4;
	logic signed [CW-1:0] sx_s4, sy_s4, du_s4, dv_s4;
	logic [AW-1:0]        a_s4;
	logic signed [BW-1:0] bh_s4;
	logic [BM-1:0]        babs_s4;
	logic [CM-1:0]        cabs_s4;
	logic                 cneg_s4, lowa_s4;
	// stage 5: b^2 and a*c
	logic                 vld_s5;
	logic signed [CW-1:0] sx_s5, sy_s5, du_s5, dv_s5;
	logic [AW-1:0]        a_s5;
	logic signed [BW-1:0] bh_s5;
	logic [PRW-1:0]       b2_s5, ac_s5;
	logic                 cneg_s5, lowa_s5;
	// stage 6: discriminant and class
	logic                 vld_s6;
	logic signed [CW-1:0] sx_s6, sy_s6, du_s6, dv_s6;
	logic [AW-1:0]        a_s6;
	logic signed [BW-1:0] bh_s6;
	logic [DW-1:0]        det_s6;
	logic                 nohit_s6, tan_s6;

	logic [PRW-1:0] d_c;
	logic           less_c;
	logic [DW-1:0]  det_c;

	// unpack the input transaction
	assign in_sx = s_tdata[CW-1:0];
	assign in_sy = s_tdata[2*CW-1:CW];
	assign in_du = s_tdata[3*CW-1:2*CW];
	assign in_dv = s_tdata[4*CW-1:3*CW];
	assign in_cx = s_tdata[5*CW-1:4*CW];
	assign in_cy = s_tdata[6*CW-1:5*CW];
	assign in_r  = s_tdata[7*CW-2:6*CW];

	// hold the whole front end while stage 6 holds a result and the queue is full
	assign fen      = !vld_s6 || !q_full;
	assign s_tready = fen;
	assign q_push   = vld_s6 && !q_full;
	assign q_data   = {det_s6, tan_s6, nohit_s6, bh_s6, a_s6, dv_s6, du_s6, sy_s6, sx_s6};

	// discriminant from b^2 and a*c
	assign less_c = (b2_s5 < ac_s5);
	assign d_c    = cneg_s5 ? (b2_s5 + ac_s5) : (b2_s5 - ac_s5);
	assign det_c  = {d_c, 2'b00};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (fen) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (fen) begin
			sx_s1 <= in_sx;
			sy_s1 <= in_sy;
			du_s1 <= in_du;
			dv_s1 <= in_dv;
			lx_s1 <= LW'(in_sx) - LW'(in_cx);
			ly_s1 <= LW'(in_sy) - LW'(in_cy);
			r_s1  <= in_r;

			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			du_s2  <= du_s1;
			dv_s2  <= dv_s1;
			uu_s2  <= du_s1 * du_s1;
			vv_s2  <= dv_s1 * dv_s1;
			ulx_s2 <= du_s1 * lx_s1;
			vly_s2 <= dv_s1 * ly_s1;
			lxx_s2 <= lx_s1 * lx_s1;
			lyy_s2 <= ly_s1 * ly_s1;
			rr_s2  <= r_s1 * r_s1;

			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			du_s3 <= du_s2;
			dv_s3 <= dv_s2;
			a_s3  <= AW'($unsigned(uu_s2)) + AW'($unsigned(vv_s2));
			bh_s3 <= BW'(ulx_s2) + BW'(vly_s2);
			c_s3  <= CWD'(lxx_s2) + CWD'(lyy_s2) - CWD'($signed({1'b0, rr_s2}));

			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			du_s4   <= du_s3;
			dv_s4   <= dv_s3;
			a_s4    <= a_s3;
			bh_s4   <= bh_s3;
			babs_s4 <= bh_s3[BW-1] ? BM'(-bh_s3) : BM'(bh_s3);
			cabs_s4 <= c_s3[CWD-1] ? CM'(-c_s3) : CM'(c_s3);
			cneg_s4 <= c_s3[CWD-1];
			lowa_s4 <= (CMPW'(a_s3) <= CMPW'(cfg.min_direction_norm));

			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			du_s5   <= du_s4;
			dv_s5   <= dv_s4;
			a_s5    <= a_s4;
			bh_s5   <= bh_s4;
			b2_s5   <= PRW'(babs_s4 * babs_s4);
			ac_s5   <= PRW'(a_s4 * cabs_s4);
			cneg_s5 <= cneg_s4;
			lowa_s5 <= lowa_s4;

			sx_s6    <= sx_s5;
			sy_s6    <= sy_s5;
			du_s6    <= du_s5;
			dv_s6    <= dv_s5;
			a_s6     <= a_s5;
			bh_s6    <= bh_s5;
			det_s6   <= det_c;
			nohit_s6 <= lowa_s5 || (!cneg_s5 && less_c);
			tan_s6   <= (det_c < DW'(cfg.tangent_tolerance));
		end
	end

endmodule

### rtl/lci_back.sv
// ----------------------------------------------------------------------------
// Line/circle intersection back end
// Pipelined square root, root selection, products, pipelined dividers and
// saturation to the output register.
// ----------------------------------------------------------------------------
module lci_back import lci_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  logic [12*COORD_WIDTH+7:0] q_data,
	output logic q_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((2*COORD_WIDTH+1)+7)/8*8-1:0] m_tdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = 2 * CW;
	localparam int BW    = 2 * CW + 2;
	localparam int DW    = 4 * CW + 4;
	localparam int SW    = DW / 2;
	localparam int NW    = 2 * CW + 4;
	localparam int PW    = NW + CW;
	localparam int DENW  = AW + 1;
	localparam int QB    = CW + 2;
	localparam int HW    = PW - QB;
	localparam int SUMW  = QB + 2;
	localparam int A_LO  = 4 * CW;
	localparam int BH_LO = A_LO + AW;
	localparam int PLW   = 4 * CW + AW + BW + 2;
	localparam int OW    = ((2 * CW + 1) + 7) / 8 * 8;

	localparam logic signed [SUMW-1:0] MAXC = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] MINC = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic en;

	// square root stages
	logic            sq_vld_q  [SW];
	logic [DW-1:0]   sq_rad_q  [SW];
	logic [SW:0]     sq_rem_q  [SW];
	logic [SW-1:0]   sq_root_q [SW];
	logic [PLW-1:0]  sq_pl_q   [SW];

	// root selection and products
	logic                 vld_m1, vld_m2, vld_m3, vld_m4;
	logic signed [NW-1:0] num_m1;
	logic [PLW-1:0]       pl_m1;
	logic signed [PW-1:0] p_m2 [2];
	logic [PW-1:0]        mag_m3 [2];
	logic                 neg_m3 [2], neg_m4 [2], ovf_m4 [2];
	logic [DENW-1:0]      rem_m4 [2];
	logic [QB-1:0]        low_m4 [2];
	logic [CW-1:0]        st_m2 [2], st_m3 [2], st_m4 [2];
	logic [DENW-1:0]      den_m2, den_m3, den_m4;
	logic                 nohit_m2, nohit_m3, nohit_m4;

	// divider stages
	logic            dv_vld_q   [QB];
	logic [DENW-1:0] dv_den_q   [QB];
	logic            dv_nohit_q [QB];
	logic [DENW-1:0] dv_rem_q   [2][QB];
	logic [QB-1:0]   dv_low_q   [2][QB];
	logic [QB-1:0]   dv_quo_q   [2][QB];
	logic            dv_neg_q   [2][QB];
	logic            dv_ovf_q   [2][QB];
	logic [CW-1:0]   dv_st_q    [2][QB];

	// output register
	logic          o_valid_q, o_hit_q;
	logic [CW-1:0] o_x_q, o_y_q;
	logic [CW-1:0] fin_sat [2];

	logic [SW-1:0]        last_root;
	logic [PLW-1:0]       last_pl;
	logic signed [BW-1:0] last_bh;

	// advance the whole back end when the output register frees up
	assign en       = !o_valid_q || m_tready;
	assign q_pop    = en && q_valid;
	assign m_tvalid = o_valid_q;
	assign m_tdata  = OW'({o_y_q, o_x_q, o_hit_q});

	// square root: one root bit per stage
	for (genvar i = 0; i < SW; i++) begin : g_sq
		logic            in_vld;
		logic [DW-1:0]   in_rad;
		logic [SW:0]     in_rem;
		logic [SW-1:0]   in_root;
		logic [PLW-1:0]  in_pl;
		logic [SW+2:0]   t_rem, t_sub, t_diff;
		logic            fit;

		if (i == 0) begin : g_head
			assign in_vld  = q_valid;
			assign in_rad  = q_data[PLW+DW-1:PLW];
			assign in_rem  = '0;
			assign in_root = '0;
			assign in_pl   = q_data[PLW-1:0];
		end else begin : g_link
			assign in_vld  = sq_vld_q[i-1];
			assign in_rad  = sq_rad_q[i-1];
			assign in_rem  = sq_rem_q[i-1];
			assign in_root = sq_root_q[i-1];
			assign in_pl   = sq_pl_q[i-1];
		end

		assign t_rem  = {in_rem, in_rad[DW-1:DW-2]};
		assign t_sub  = {1'b0, in_root, 2'b01};
		assign fit    = (t_rem >= t_sub);
		assign t_diff = t_rem - t_sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_q[i] <= 1'b0;
			end else if (en) begin
				sq_vld_q[i] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_q[i]  <= {in_rad[DW-3:0], 2'b00};
				sq_rem_q[i]  <= fit ? t_diff[SW:0] : t_rem[SW:0];
				sq_root_q[i] <= {in_root[SW-2:0], fit};
				sq_pl_q[i]   <= in_pl;
			end
		end
	end

	assign last_root = sq_root_q[SW-1];
	assign last_pl   = sq_pl_q[SW-1];
	assign last_bh   = last_pl[BH_LO +: BW];

	// valid bits of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			vld_m3 <= 1'b0;
			vld_m4 <= 1'b0;
		end else if (en) begin
			vld_m1 <= sq_vld_q[SW-1];
			vld_m2 <= vld_m1;
			vld_m3 <= vld_m2;
			vld_m4 <= vld_m3;
		end
	end

	// select the numerator, multiply by direction, split sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			num_m1 <= (last_pl[PLW-1] ? NW'(0) : NW'($signed({1'b0, last_root})))
				- (NW'(last_bh) <<< 1);
			pl_m1  <= last_pl;

			p_m2[0]  <= num_m1 * $signed(pl_m1[2*CW +: CW]);
			p_m2[1]  <= num_m1 * $signed(pl_m1[3*CW +: CW]);
			st_m2[0] <= pl_m1[0 +: CW];
			st_m2[1] <= pl_m1[CW +: CW];
			den_m2   <= {pl_m1[A_LO +: AW], 1'b0};
			nohit_m2 <= pl_m1[PLW-2];

			for (int k = 0; k < 2; k++) begin
				neg_m3[k] <= p_m2[k][PW-1];
				mag_m3[k] <= p_m2[k][PW-1] ? PW'(-p_m2[k]) : PW'(p_m2[k]);
				st_m3[k]  <= st_m2[k];

				ovf_m4[k] <= (mag_m3[k][PW-1:QB] >= HW'(den_m3));
				rem_m4[k] <= mag_m3[k][QB +: DENW];
				low_m4[k] <= mag_m3[k][QB-1:0];
				neg_m4[k] <= neg_m3[k];
				st_m4[k]  <= st_m3[k];
			end
			den_m3   <= den_m2;
			nohit_m3 <= nohit_m2;
			den_m4   <= den_m3;
			nohit_m4 <= nohit_m3;
		end
	end

	// division: one quotient bit per stage, both axes side by side
	for (genvar j = 0; j < QB; j++) begin : g_dv
		logic            in_vld;
		logic [DENW-1:0] in_den;
		logic            in_nohit;

		if (j == 0) begin : g_head
			assign in_vld   = vld_m4;
			assign in_den   = den_m4;
			assign in_nohit = nohit_m4;
		end else begin : g_link
			assign in_vld   = dv_vld_q[j-1];
			assign in_den   = dv_den_q[j-1];
			assign in_nohit = dv_nohit_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_q[j] <= 1'b0;
			end else if (en) begin
				dv_vld_q[j] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_q[j]   <= in_den;
				dv_nohit_q[j] <= in_nohit;
			end
		end

		for (genvar k = 0; k < 2; k++) begin : g_ax
			logic [DENW-1:0] in_rem;
			logic [QB-1:0]   in_low, in_quo;
			logic            in_neg, in_ovf;
			logic [CW-1:0]   in_st;
			logic [DENW:0]   t_rem, t_diff;
			logic            fit;

			if (j == 0) begin : g_head
				assign in_rem = rem_m4[k];
				assign in_low = low_m4[k];
				assign in_quo = '0;
				assign in_neg = neg_m4[k];
				assign in_ovf = ovf_m4[k];
				assign in_st  = st_m4[k];
			end else begin : g_link
				assign in_rem = dv_rem_q[k][j-1];
				assign in_low = dv_low_q[k][j-1];
				assign in_quo = dv_quo_q[k][j-1];
				assign in_neg = dv_neg_q[k][j-1];
				assign in_ovf = dv_ovf_q[k][j-1];
				assign in_st  = dv_st_q[k][j-1];
			end

			assign t_rem  = {in_rem, in_low[QB-1]};
			assign fit    = (t_rem >= {1'b0, in_den});
			assign t_diff = t_rem - {1'b0, in_den};

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_q[k][j] <= fit ? t_diff[DENW-1:0] : t_rem[DENW-1:0];
					dv_low_q[k][j] <= {in_low[QB-2:0], 1'b0};
					dv_quo_q[k][j] <= {in_quo[QB-2:0], fit};
					dv_neg_q[k][j] <= in_neg;
					dv_ovf_q[k][j] <= in_ovf;
					dv_st_q[k][j]  <= in_st;
				end
			end
		end
	end

	// apply sign, add start point, saturate
	for (genvar k = 0; k < 2; k++) begin : g_fin
		logic [QB-1:0]          q;
		logic signed [QB:0]     sq;
		logic signed [SUMW-1:0] sum;

		assign q   = dv_ovf_q[k][QB-1] ? '1 : dv_quo_q[k][QB-1];
		assign sq  = dv_neg_q[k][QB-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		assign sum = SUMW'($signed(dv_st_q[k][QB-1])) + SUMW'(sq);
		assign fin_sat[k] = (sum > MAXC) ? CW'(MAXC) : ((sum < MINC) ? CW'(MINC) : CW'(sum));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (en) begin
			o_valid_q <= dv_vld_q[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_hit_q <= !dv_nohit_q[QB-1];
			o_x_q   <= dv_nohit_q[QB-1] ? '0 : fin_sat[0];
			o_y_q   <= dv_nohit_q[QB-1] ? '0 : fin_sat[1];
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && !o_hit_q |-> (o_x_q == '0) && (o_y_q == '0))
		else $error("miss reported with nonzero impact point");

endmodule

### rtl/line_circle_intersection_unit.sv
// ----------------------------------------------------------------------------
// Line/circle intersection unit
// Solves the ray/circle quadratic in fixed point and returns the impact
// point of the far root (or the tangent point), saturated to the coordinate
// range.
//
//   channel   dir  signals                      contents
//   s_axis    in   s_tvalid s_tready s_tdata    start, direction, circle
//   m_axis    out  m_tvalid m_tready m_tdata    hit flag, impact x/y
//   apb       in   psel penable pwrite paddr... two 32-bit registers
//
// Takes one ray per clock unless m_tready or a full queue holds it. The
// square root resolves one root bit per stage and the dividers one
// quotient bit per stage.
// Reset clears all valid bits and both registers at once; no sweep.
// m_tready low holds the back end; the queue keeps taking front-end results
// until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module line_circle_intersection_unit import lci_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// {circle_radius, center_y, center_x, dir_v, dir_u, start_y, start_x}
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((7*COORD_WIDTH-1)+7)/8*8-1:0] s_tdata,
	// {impact_y, impact_x, hit}
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((2*COORD_WIDTH+1)+7)/8*8-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int QW = 12 * COORD_WIDTH + 8;

	lci_cfg_t      cfg_q;
	logic          cfg_wr;
	lci_reg_t      reg_sel;
	logic          q_push, q_pop, q_full, q_valid;
	logic [QW-1:0] q_wdata, q_rdata;

	// register access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = lci_reg_t'(paddr[REG_SEL_BIT]);

	always_comb begin
		unique case (reg_sel)
			REG_MIN_DIRECTION_NORM: prdata = cfg_q.min_direction_norm;
			REG_TANGENT_TOLERANCE:  prdata = cfg_q.tangent_tolerance;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MIN_DIRECTION_NORM: cfg_q.min_direction_norm <= pwdata;
				REG_TANGENT_TOLERANCE:  cfg_q.tangent_tolerance  <= pwdata;
			endcase
		end
	end

	lci_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	lci_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid)
	);

	lci_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### tb/sv/line_circle_intersection_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line/circle intersection unit testbench
// Drives rays and circles into the stream input, predicts the impact point
// of each in fixed point, and checks every result in order. Runs several
// register settings with random idling on both sides and one long output
// stall that backs the unit up.
// ----------------------------------------------------------------------------
module line_circle_intersection_unit_test;
	import lci_pkg::*;

	localparam int CW       = 16;
	localparam int IN_W     = ((7*CW-1)+7)/8*8;
	localparam int OUT_W    = ((2*CW+1)+7)/8*8;
	localparam int LATENCY  = 3*CW+16;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic signed [CW-1:0] start_x, start_y, dir_u, dir_v, center_x, center_y;
		logic [CW-2:0]        radius;
	} ray_t;

	typedef struct {
		logic                 hit;
		logic signed [CW-1:0] impact_x, impact_y;
	} impact_t;

	// Expected impact points and the register copies they depend on
	class impact_board;
		logic [31:0] min_norm;
		logic [31:0] tan_tol;
		impact_t     pending[$];
		int          mismatches;

		function longint sat(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function logic signed [127:0] root_floor(logic signed [127:0] d);
			logic signed [127:0] r, c;
			r = 0;
			for (int b = 36; b >= 0; b--) begin
				c = r | (128'sd1 <<< b);
				if (c * c <= d)
					r = c;
			end
			return r;
		endfunction

		function void note_ray(ray_t t);
			longint sx, sy, u, v, lx, ly, a, bh, c, num, den;
			logic signed [127:0] det, tol;
			impact_t e;
			sx = t.start_x; sy = t.start_y; u = t.dir_u; v = t.dir_v;
			lx = sx - longint'(t.center_x);
			ly = sy - longint'(t.center_y);
			a  = u*u + v*v;
			bh = u*lx + v*ly;
			c  = lx*lx + ly*ly - longint'(t.radius) * longint'(t.radius);
			e = '{hit: 1'b0, impact_x: '0, impact_y: '0};
			if (a > longint'(min_norm)) begin
				det = 4 * (128'(signed'(bh)) * 128'(signed'(bh))
					- 128'(signed'(a)) * 128'(signed'(c)));
				if (det >= 0) begin
					tol = {96'd0, tan_tol};
					num = -2 * bh;
					if (!(det < tol))
						num += longint'(root_floor(det));
					den = 2 * a;
					e.hit = 1'b1;
					e.impact_x = CW'(sat(sx + (num * u) / den));
					e.impact_y = CW'(sat(sy + (num * v) / den));
				end
			end
			pending.push_back(e);
		endfunction

		function void check_impact(impact_t got);
			impact_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hit=%0d x=%0d y=%0d",
						got.hit, got.impact_x, got.impact_y);
				return;
			end
			e = pending.pop_front();
			if (e.hit !== got.hit || e.impact_x !== got.impact_x
				|| e.impact_y !== got.impact_y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
						e.hit, e.impact_x, e.impact_y, got.hit, got.impact_x, got.impact_y);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// {pad, circle_radius, center_y, center_x, dir_v, dir_u, start_y, start_x}
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// {pad, impact_y, impact_x, hit}
	logic [OUT_W-1:0]  m_tdata;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic              pready;

	impact_board board = new();
	int  rx_idle_pct = 0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;

	line_circle_intersection_unit #(.COORD_WIDTH(CW)) uut (.*);

	always #5 clk = ~clk;

	// Receiver readiness: random idling plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_request <= 1'b0;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Note accepted rays, check accepted results, watch for a hang
	always @(posedge clk) begin
		ray_t    t;
		impact_t got;
		if (s_tvalid && s_tready) begin
			t.start_x  = s_tdata[15:0];
			t.start_y  = s_tdata[31:16];
			t.dir_u    = s_tdata[47:32];
			t.dir_v    = s_tdata[63:48];
			t.center_x = s_tdata[79:64];
			t.center_y = s_tdata[95:80];
			t.radius   = s_tdata[110:96];
			board.note_ray(t);
		end
		if (m_tvalid && m_tready) begin
			got.hit      = m_tdata[0];
			got.impact_x = m_tdata[16:1];
			got.impact_y = m_tdata[32:17];
			board.check_impact(got);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("line_circle_intersection_unit_test NOT OK");
			$finish;
		end
	end

	// Register write over the configuration port; the unit is idle here
	task automatic write_reg(lci_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= CFG_ADDR_W'(idx) << REG_SEL_BIT;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_MIN_DIRECTION_NORM)
			board.min_norm = val;
		else
			board.tan_tol = val;
	endtask

	// Offer one ray and hold it until the unit takes the transaction
	task automatic send_ray(ray_t t, int idle_pct);
		bit rdy;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, t.radius, t.center_y, t.center_x, t.dir_v, t.dir_u,
			t.start_y, t.start_x};
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy)
				break;
		end
	endtask

	function automatic ray_t make_ray(int x0, int y0, int u, int v, int cx, int cy, int r);
		ray_t t;
		t.start_x = CW'(x0); t.start_y = CW'(y0);
		t.dir_u = CW'(u); t.dir_v = CW'(v);
		t.center_x = CW'(cx); t.center_y = CW'(cy);
		t.radius = (CW-1)'(r);
		return t;
	endfunction

	// Mostly rays aimed near a circle, the rest fully random
	function automatic ray_t random_ray();
		ray_t t;
		int sx, sy, cx, cy;
		if ($urandom_range(99) < 30) begin
			t.start_x = CW'($urandom); t.start_y = CW'($urandom);
			t.dir_u = CW'($urandom); t.dir_v = CW'($urandom);
			t.center_x = CW'($urandom); t.center_y = CW'($urandom);
			t.radius = (CW-1)'($urandom);
		end else begin
			sx = $urandom_range(4096) - 2048; sy = $urandom_range(4096) - 2048;
			cx = $urandom_range(4096) - 2048; cy = $urandom_range(4096) - 2048;
			t = make_ray(sx, sy,
				((cx - sx) >>> $urandom_range(4)) + $urandom_range(64) - 32,
				((cy - sy) >>> $urandom_range(4)) + $urandom_range(64) - 32,
				cx, cy, $urandom_range(4095));
		end
		return t;
	endfunction

	// Wait for every expected result, then let the pipeline drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 16) @(posedge clk);
	endtask

	task automatic random_run(int count, int idle_pct);
		for (int i = 0; i < count; i++)
			send_ray(random_ray(), idle_pct);
	endtask

	initial begin
		board.min_norm = 0;
		board.tan_tol = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, degenerate direction, tangent, saturation
		write_reg(REG_MIN_DIRECTION_NORM, 32'd0);
		write_reg(REG_TANGENT_TOLERANCE, 32'd0);
		rx_idle_pct = 53;
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 0), 17);
		send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 32767), 17);
		send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 32767), 17);
		send_ray(make_ray(-32768, 32767, 32767, -32768, 32767, -32768, 0), 17);
		send_ray(make_ray(0, 0, 256, 0, 0, 0, 256), 17);
		send_ray(make_ray(0, -256, 256, 0, 0, 0, 256), 17);
		send_ray(make_ray(0, -257, 256, 0, 0, 0, 256), 17);
		send_ray(make_ray(0, 0, 1, 0, 0, 0, 0), 17);
		send_ray(make_ray(32000, 0, 1, 0, 0, 0, 32767), 17);
		send_ray(make_ray(-32000, -32000, 1, 1, 32000, 32000, 32767), 17);
		send_ray(make_ray(0, 0, 0, 1, 0, 0, 32767), 17);
		send_ray(make_ray(1000, 1000, -256, -256, 0, 0, 512), 17);
		random_run(290, 17);
		drain();

		// All-ones registers: every ray is rejected
		write_reg(REG_MIN_DIRECTION_NORM, 32'hFFFF_FFFF);
		write_reg(REG_TANGENT_TOLERANCE, 32'hFFFF_FFFF);
		random_run(12, 17);
		drain();

		// Mid-range threshold and tolerance, idling swapped
		write_reg(REG_MIN_DIRECTION_NORM, $urandom_range(65535));
		write_reg(REG_TANGENT_TOLERANCE, $urandom);
		rx_idle_pct = 17;
		random_run(300, 53);
		drain();

		// No idling, wide tangent tolerance, one long output stall
		write_reg(REG_MIN_DIRECTION_NORM, 32'd0);
		write_reg(REG_TANGENT_TOLERANCE, 32'hFFFF_FFFF);
		rx_idle_pct = 0;
		hold_request = 1'b1;
		random_run(300, 0);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("line_circle_intersection_unit_test OK");
		else
			$display("line_circle_intersection_unit_test NOT OK");
		$finish;
	end

endmodule
